// File: hdl/btk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package btk_pkg;

  localparam int MAX_ENTRIES  = 8;
  localparam int PAYLOAD_BITS = 32;
  localparam int KEY_W        = 32;
  localparam int IDX_W        = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W        = $clog2(MAX_ENTRIES + 1);
  localparam int CAP_W        = 4;
  localparam int CAP_RESET    = 5;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [PAYLOAD_BITS-1:0] payload_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [IDX_W-1:0]        idx_t;

  // Request codes on the input channel.
  typedef enum logic [1:0] {
    REQ_INSERT  = 2'd0,
    REQ_EXTRACT = 2'd1,
    REQ_PRUNE   = 2'd2,
    REQ_NOP     = 2'd3
  } req_t;

  // What every cell does in a given cycle.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT
  } cell_op_t;

  // Broadcast from the control to all cells.
  typedef struct packed {
    cell_op_t op;
    key_t     key;
    payload_t payload;
    cnt_t     count;
  } cell_ctrl_t;

  // What a cell shows its neighbors.
  typedef struct packed {
    logic     ge;
    key_t     key;
    payload_t payload;
  } cell_link_t;

  // One result transaction.
  typedef struct packed {
    key_t     key;
    payload_t payload;
    logic     was_empty;
    logic     prune;
    cnt_t     fill_count;
  } result_t;

endpackage

`default_nettype wire

// File: hdl/btk_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module btk_cell (
  input  wire                     clk,
  input  btk_pkg::idx_t           idx,
  input  btk_pkg::cell_ctrl_t     ctrl,
  input  btk_pkg::cell_link_t     left_in,
  input  btk_pkg::cell_link_t     right_in,
  output btk_pkg::cell_link_t     link_out,
  output logic                    prune_hit
);
  import btk_pkg::*;

  key_t     key_r;
  payload_t payload_r;
  logic     occupied;
  cnt_t     idx_ext;

  assign idx_ext  = cnt_t'(idx);
  assign occupied = idx_ext < ctrl.count;

  // The cell belongs to the tail once it is empty or holds a larger key.
  assign link_out.ge      = !occupied || (key_r > ctrl.key);
  assign link_out.key     = key_r;
  assign link_out.payload = payload_r;

  // This cell holds the last stored entry and the query key reaches it.
  assign prune_hit = ((idx_ext + cnt_t'(1)) == ctrl.count) && (ctrl.key >= key_r);

  always_ff @(posedge clk) begin
    case (ctrl.op)
      CELL_INSERT: begin
        if (link_out.ge) begin
          if (!left_in.ge) begin
            key_r     <= ctrl.key;
            payload_r <= ctrl.payload;
          end else begin
            key_r     <= left_in.key;
            payload_r <= left_in.payload;
          end
        end
      end
      CELL_SHIFT: begin
        key_r     <= right_in.key;
        payload_r <= right_in.payload;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/btk_out_skid.sv
`timescale 1ns / 1ps
`default_nettype none

module btk_out_skid (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  btk_pkg::result_t    push_data,
  output logic                full,
  output logic                out_valid,
  input  wire                 out_stall,
  output btk_pkg::result_t    out_data
);
  import btk_pkg::*;

  logic    main_v_r, skid_v_r;
  result_t main_r, skid_r;
  logic    take;

  assign take      = main_v_r && !out_stall;
  assign full      = skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (take) begin
      if (skid_v_r) begin
        main_r   <= skid_r;
        skid_v_r <= 1'b0;
      end else if (push) begin
        main_r <= push_data;
      end else begin
        main_v_r <= 1'b0;
      end
    end else if (push) begin
      if (main_v_r) begin
        skid_r   <= push_data;
        skid_v_r <= 1'b1;
      end else begin
        main_r   <= push_data;
        main_v_r <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/bounded_top_k_sorted_list_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_stall    in_req_type, in_entry_key, in_entry_payload
// out_      output     out_valid / out_stall  out_key, out_payload, out_was_empty,
//                                              out_prune, out_fill_count
// cfg_      input      APB-style write/read   capacity at byte address 0
//
// Each transaction is handled in the cycle it is accepted: one request per clock while
// in_stall is low. The row of cells updates at the accepting edge; the result lands in
// a two-entry output buffer.
// in_stall rises only while both output buffer entries hold untaken results.
// Reset (rst_n low, synchronous) empties the list and sets the capacity to 5;
// stored keys and payloads are not cleared, the fill count alone marks them live.

module bounded_top_k_sorted_list_core (
  input  wire                      clk,
  input  wire                      rst_n,
  // Request channel
  input  wire                      in_valid,
  output logic                     in_stall,
  input  wire [1:0]                in_req_type,
  input  wire signed [btk_pkg::KEY_W-1:0]    in_entry_key,
  input  wire [btk_pkg::PAYLOAD_BITS-1:0]    in_entry_payload,
  // Result channel
  output logic                     out_valid,
  input  wire                      out_stall,
  output logic signed [btk_pkg::KEY_W-1:0]   out_key,
  output logic [btk_pkg::PAYLOAD_BITS-1:0]   out_payload,
  output logic                     out_was_empty,
  output logic                     out_prune,
  output logic [btk_pkg::CNT_W-1:0]          out_fill_count,
  // Configuration port
  input  wire                      cfg_psel,
  input  wire                      cfg_penable,
  input  wire                      cfg_pwrite,
  input  wire [2:0]                cfg_paddr,
  input  wire [31:0]               cfg_pwdata,
  output logic [31:0]              cfg_prdata,
  output logic                     cfg_pready
);
  import btk_pkg::*;

  localparam logic REG_CAPACITY = 1'b0;

  logic [CAP_W-1:0] cap_r;
  cnt_t             count_r, count_nxt;
  cnt_t             eff_cap;
  logic             accept;
  req_t             req;
  cell_ctrl_t       ctrl;
  cell_link_t       links [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] hits;
  result_t          res;
  result_t          out_data;
  logic             buf_full;
  logic             cfg_write;

  // The capacity register. Only register index 0 exists; its address bit 2 is zero.
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_CAPACITY) ? 32'(cap_r) : 32'd0;

  // A capacity of zero acts as one, and anything above the built depth as the depth.
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = cnt_t'(1);
    end else if (cnt_t'(cap_r) > cnt_t'(MAX_ENTRIES)) begin
      eff_cap = cnt_t'(MAX_ENTRIES);
    end else begin
      eff_cap = cnt_t'(cap_r);
    end
  end

  assign in_stall = buf_full;
  assign accept   = in_valid && !in_stall;
  assign req      = req_t'(in_req_type);

  // Decode the request into the operation broadcast to the row and the next fill.
  always_comb begin
    ctrl.op      = CELL_HOLD;
    ctrl.key     = in_entry_key;
    ctrl.payload = in_entry_payload;
    ctrl.count   = count_r;
    count_nxt    = count_r;
    res          = '0;
    case (req)
      REQ_INSERT: begin
        if (accept) begin
          ctrl.op = CELL_INSERT;
        end
        // One entry falls off the tail when the list would exceed the capacity.
        if ((count_r + cnt_t'(1)) <= eff_cap) begin
          count_nxt = count_r + cnt_t'(1);
        end
      end
      REQ_EXTRACT: begin
        if (count_r == '0) begin
          res.was_empty = 1'b1;
        end else begin
          if (accept) begin
            ctrl.op = CELL_SHIFT;
          end
          res.key     = links[0].key;
          res.payload = links[0].payload;
          count_nxt   = count_r - cnt_t'(1);
        end
      end
      REQ_PRUNE: begin
        res.prune = (count_r >= eff_cap) && (count_r != '0) && (|hits);
      end
      default: begin
      end
    endcase
    res.fill_count = count_nxt;
  end

  // The row of cells: entry 0 holds the smallest key.
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    cell_link_t left_link, right_link;

    if (i == 0) begin : g_head
      assign left_link = '0;
    end else begin : g_body
      assign left_link = links[i-1];
    end

    if (i == MAX_ENTRIES - 1) begin : g_tail
      assign right_link = links[i];
    end else begin : g_mid
      assign right_link = links[i+1];
    end

    btk_cell u_cell (
      .clk       (clk),
      .idx       (idx_t'(i)),
      .ctrl      (ctrl),
      .left_in   (left_link),
      .right_in  (right_link),
      .link_out  (links[i]),
      .prune_hit (hits[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAP_W'(CAP_RESET);
      count_r <= '0;
    end else begin
      if (cfg_write && (cfg_paddr[2] == REG_CAPACITY)) begin
        cap_r <= cfg_pwdata[CAP_W-1:0];
      end
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  // Results wait here so that a stalled result does not block the next request.
  btk_out_skid u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_key        = out_data.key;
  assign out_payload    = out_data.payload;
  assign out_was_empty  = out_data.was_empty;
  assign out_prune      = out_data.prune;
  assign out_fill_count = out_data.fill_count;

  // The fill never goes past the built depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cnt_t'(MAX_ENTRIES))
    else $error("fill count exceeds depth");

  // A stalled input means a result is being held for the output.
  a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  // Extracting from a non-empty list removes exactly one entry.
  a_extract_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (req == REQ_EXTRACT) && (count_r != '0)) |=>
      (count_r == $past(count_r) - cnt_t'(1)))
    else $error("extract did not remove one entry");

  // An insert never shrinks the list.
  a_insert_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (req == REQ_INSERT)) |=> (count_r >= $past(count_r)))
    else $error("insert shrank the list");

endmodule

`default_nettype wire
